// File: design/life_generation_row_stencil_defines.svh
// Assertion macros for the row stencil block.
// Each macro takes a label, a trigger and a consequence, clocked on clk and
// disabled during rst.
`ifndef LIFE_GENERATION_ROW_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_ROW_STENCIL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// consequence holds in the same cycle as the trigger
`define LGRS_ASSERT_SAME(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("lgrs: same-cycle check failed");
// consequence holds in the cycle after the trigger
`define LGRS_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("lgrs: next-cycle check failed");
`else
`define LGRS_ASSERT_SAME(label, trig, cons)
`define LGRS_ASSERT_NEXT(label, trig, cons)
`endif

`endif

// File: design/lgrs_pkg.sv
`default_nettype none

package lgrs_pkg;

  // fixed field widths
  localparam int ROW_BITS   = 64;
  localparam int WIDTH_BITS = 7;

  // default number of columns the hardware holds
  localparam int MAX_WIDTH_DEF = 64;

  // grid width after reset
  localparam logic [WIDTH_BITS-1:0] GRID_WIDTH_RESET = 7'd64;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // result queue depth, power of two, at least 4
  localparam int QUEUE_DEPTH = 4;

  // one result item
  typedef struct packed {
    logic [ROW_BITS-1:0] next_row;
    logic                last_out;
  } result_t;

  // which of the two result slots an accepted row fills
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

// File: design/lgrs_lane.sv
`default_nettype none

// One cell: next state from its 3x3 window (bit 1 of each is this column).
module lgrs_lane (
  input  wire logic [2:0] up,
  input  wire logic [2:0] mid,
  input  wire logic [2:0] down,
  input  wire logic       col_en,
  output logic            next_cell
);

  logic [3:0] neighbours;

  // eight neighbours, centre excluded
  assign neighbours = {3'b000, up[0]}   + {3'b000, up[1]}   + {3'b000, up[2]}
                    + {3'b000, mid[0]}                      + {3'b000, mid[2]}
                    + {3'b000, down[0]} + {3'b000, down[1]} + {3'b000, down[2]};

  assign next_cell = col_en & ((neighbours == lgrs_pkg::BIRTH_COUNT) |
                               (mid[1] & (neighbours == lgrs_pkg::SURVIVE_COUNT)));

endmodule

`default_nettype wire

// File: design/lgrs_evolve.sv
`default_nettype none

// Row of lanes, one per column, merged into one masked result row.
module lgrs_evolve #(
  parameter int MAX_WIDTH = lgrs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic [MAX_WIDTH-1:0]            up,
  input  wire logic [MAX_WIDTH-1:0]            mid,
  input  wire logic [MAX_WIDTH-1:0]            down,
  input  wire logic [lgrs_pkg::WIDTH_BITS-1:0] grid_width,
  output logic      [lgrs_pkg::ROW_BITS-1:0]   row
);

  logic [MAX_WIDTH-1:0] col_en;
  logic [MAX_WIDTH+1:0] up_pad;
  logic [MAX_WIDTH+1:0] mid_pad;
  logic [MAX_WIDTH+1:0] down_pad;
  logic [MAX_WIDTH-1:0] lane_out;

  // column enables from the configured width
  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      col_en[j] = (grid_width > lgrs_pkg::WIDTH_BITS'(j));
    end
  end

  // mask and pad with a dead column on each side
  assign up_pad   = {1'b0, up   & col_en, 1'b0};
  assign mid_pad  = {1'b0, mid  & col_en, 1'b0};
  assign down_pad = {1'b0, down & col_en, 1'b0};

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_lane
    lgrs_lane u_lane (
      .up       (up_pad[j+2:j]),
      .mid      (mid_pad[j+2:j]),
      .down     (down_pad[j+2:j]),
      .col_en   (col_en[j]),
      .next_cell(lane_out[j])
    );
  end

  // merge lanes into the full-width row
  always_comb begin
    row                = '0;
    row[MAX_WIDTH-1:0] = lane_out;
  end

endmodule

`default_nettype wire

// File: design/lgrs_queue.sv
`default_nettype none

// Result queue: takes up to two results per cycle, hands out one.
module lgrs_queue #(
  parameter int DEPTH = lgrs_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lgrs_pkg::push_t   push,
  input  wire lgrs_pkg::result_t data_first,
  input  wire lgrs_pkg::result_t data_second,
  output logic                   has_room,
  output logic                   head_valid,
  output lgrs_pkg::result_t      head,
  input  wire logic              pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lgrs_pkg::result_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       num_push;
  logic             do_pop;

  assign num_push = {1'b0, push.first} + {1'b0, push.second};
  assign do_pop   = pop & head_valid;

  always_comb begin
    count_next = count + CNT_W'(num_push) - CNT_W'(do_pop);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= data_first;
    end
    if (push.second) begin
      mem[wr_ptr + PTR_W'(1)] <= data_second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(num_push);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  // room for the two results a final row may bring
  assign has_room   = (count <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

// File: design/life_generation_row_stencil.sv
// One Game of Life generation (B3/S23), one grid row per request.
// A result is queued when the row that completes it is taken; one row per
// cycle is taken while the four-entry result queue has room, and a final row
// yields two results if a row is held, drained one per cycle while out_ready.
// Reset (rst, synchronous): grid_width to 64, held rows cleared, queue empty.
`default_nettype none

`include "life_generation_row_stencil_defines.svh"

module life_generation_row_stencil #(
  parameter int MAX_WIDTH = lgrs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lgrs_pkg::WIDTH_BITS-1:0] cfg_data,
  // row input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lgrs_pkg::ROW_BITS-1:0]   row_cells,
  input  wire logic                            last_row,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [lgrs_pkg::ROW_BITS-1:0]   next_row,
  output logic                                 last_out
);

  logic [lgrs_pkg::WIDTH_BITS-1:0] grid_width;
  logic [MAX_WIDTH-1:0]            row_above;
  logic [MAX_WIDTH-1:0]            row_middle;
  logic                            have_middle;

  logic [MAX_WIDTH-1:0]          row_in;
  logic [MAX_WIDTH-1:0]          col_mask;
  logic [MAX_WIDTH-1:0]          row_kept;
  logic                          accept;
  logic [lgrs_pkg::ROW_BITS-1:0] inner_row;
  logic [lgrs_pkg::ROW_BITS-1:0] bottom_row;
  lgrs_pkg::push_t               push;
  lgrs_pkg::result_t             res_first;
  lgrs_pkg::result_t             res_second;
  lgrs_pkg::result_t             head;

  assign row_in    = row_cells[MAX_WIDTH-1:0];
  assign accept    = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // columns in use at the time a row is taken
  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      col_mask[j] = (grid_width > lgrs_pkg::WIDTH_BITS'(j));
    end
  end

  // a held row keeps the mask it came in with
  assign row_kept = row_in & col_mask;

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= lgrs_pkg::GRID_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_width <= cfg_data;
    end
  end

  // row window: held row and the one above it
  always_ff @(posedge clk) begin
    if (rst) begin
      row_above   <= '0;
      row_middle  <= '0;
      have_middle <= 1'b0;
    end else if (accept) begin
      if (last_row) begin
        row_above   <= '0;
        row_middle  <= '0;
        have_middle <= 1'b0;
      end else begin
        row_above   <= have_middle ? row_middle : '0;
        row_middle  <= row_kept;
        have_middle <= 1'b1;
      end
    end
  end

  // held row with the new row below it
  lgrs_evolve #(.MAX_WIDTH(MAX_WIDTH)) u_inner (
    .up        (row_above),
    .mid       (row_middle),
    .down      (row_in),
    .grid_width(grid_width),
    .row       (inner_row)
  );

  // new row as bottom edge; held row is zero when none is held
  lgrs_evolve #(.MAX_WIDTH(MAX_WIDTH)) u_bottom (
    .up        (row_middle),
    .mid       (row_in),
    .down      ('0),
    .grid_width(grid_width),
    .row       (bottom_row)
  );

  // result slots in output order
  always_comb begin
    push.first           = accept & (have_middle | last_row);
    push.second          = accept & have_middle & last_row;
    res_first.next_row   = have_middle ? inner_row : bottom_row;
    res_first.last_out   = ~have_middle;
    res_second.next_row  = bottom_row;
    res_second.last_out  = 1'b1;
  end

  lgrs_queue #(.DEPTH(lgrs_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_first (res_first),
    .data_second(res_second),
    .has_room   (in_ready),
    .head_valid (out_valid),
    .head       (head),
    .pop        (out_ready)
  );

  assign next_row = head.next_row;
  assign last_out = head.last_out;

  // checks
  `LGRS_ASSERT_NEXT(a_last_clears, accept && last_row, !have_middle)
  `LGRS_ASSERT_NEXT(a_row_held, accept && !last_row, have_middle)
  `LGRS_ASSERT_NEXT(a_last_gives_result, accept && last_row, out_valid)
  `LGRS_ASSERT_SAME(a_pair_only_with_first, push.second, push.first)

endmodule

`default_nettype wire

// File: tb/sv/tb_life_generation_row_stencil.sv
`timescale 1ns / 100ps

module tb_life_generation_row_stencil;

  localparam int CLK_HALF   = 6;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_LEN   = 80;
  localparam int RAND_ROWS  = 650;
  localparam int CFG_SETTLE = 4;
  localparam int END_SETTLE = 10;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [lgrs_pkg::WIDTH_BITS-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [lgrs_pkg::ROW_BITS-1:0]     row_cells;
  logic                              last_row;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [lgrs_pkg::ROW_BITS-1:0]     next_row;
  logic                              last_out;

  // stimulus control shared with the receiver
  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;

  int fail_count = 0;
  int rows_sent  = 0;
  int idle_cycles = 0;

  // predicted generation state
  logic [lgrs_pkg::WIDTH_BITS-1:0] width_reg;
  logic [63:0]                     above_row;
  logic [63:0]                     held_row;
  bit                              row_held;
  lgrs_pkg::result_t               expected_rows[$];

  life_generation_row_stencil DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .row_cells (row_cells),
    .last_row  (last_row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .next_row  (next_row),
    .last_out  (last_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // columns in use; widths above 64 saturate
  function automatic logic [63:0] live_column_mask(input logic [lgrs_pkg::WIDTH_BITS-1:0] w);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // B3/S23 update of the middle row, rows outside the grid dead
  function automatic logic [63:0] life_next_row(input logic [63:0] up, input logic [63:0] mid,
                                                input logic [63:0] dn, input logic [63:0] m);
    logic [63:0] nxt;
    int n;
    nxt = '0;
    up  = up & m;
    mid = mid & m;
    dn  = dn & m;
    for (int j = 0; j < 64; j++) begin
      n = int'(up[j]) + int'(dn[j]);
      if (j > 0) n += int'(up[j-1]) + int'(mid[j-1]) + int'(dn[j-1]);
      if (j < 63) n += int'(up[j+1]) + int'(mid[j+1]) + int'(dn[j+1]);
      if (n == int'(lgrs_pkg::BIRTH_COUNT) ||
          (mid[j] && n == int'(lgrs_pkg::SURVIVE_COUNT)))
        nxt[j] = 1'b1;
    end
    return nxt & m;
  endfunction

  // append one expected result at the tail
  function automatic void add_expected(input lgrs_pkg::result_t r);
    expected_rows = {expected_rows, r};
  endfunction

  // expected results for one accepted row
  task automatic predict_rows(input logic [63:0] raw, input logic last);
    logic [63:0] m;
    logic [63:0] row;
    lgrs_pkg::result_t r;
    m   = live_column_mask(width_reg);
    row = raw & m;
    if (row_held) begin
      r.next_row = life_next_row(above_row, held_row, row, m);
      r.last_out = 1'b0;
      add_expected(r);
      if (last) begin
        r.next_row = life_next_row(held_row, row, '0, m);
        r.last_out = 1'b1;
        add_expected(r);
        above_row = '0;
        held_row  = '0;
        row_held  = 1'b0;
      end else begin
        above_row = held_row;
        held_row  = row;
      end
    end else if (last) begin
      r.next_row = life_next_row('0, row, '0, m);
      r.last_out = 1'b1;
      add_expected(r);
    end else begin
      above_row = '0;
      held_row  = row;
      row_held  = 1'b1;
    end
  endtask

  // gap length, mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // offer one row request and wait until it is taken
  task automatic send_row(input logic [63:0] cells, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    row_cells <= cells;
    last_row  <= last;
    do @(posedge clk); while (!in_ready);
    predict_rows(cells, last);
    rows_sent++;
  endtask

  // width write, only once the block has drained
  task automatic write_grid_width(input logic [lgrs_pkg::WIDTH_BITS-1:0] w);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_row();
    logic [63:0] a;
    logic [63:0] b;
    int r;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r < 5) return a;
    if (r < 7) return a & b;
    if (r < 9) return a | b;
    return '0;
  endfunction

  function automatic logic [lgrs_pkg::WIDTH_BITS-1:0] random_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 7'd127;
    if (r == 2) return 7'($urandom_range(65, 126));
    if (r < 6)  return 7'd64;
    return 7'($urandom_range(1, 64));
  endfunction

  // one full frame of random rows
  task automatic send_frame(input int height);
    for (int k = 0; k < height; k++)
      send_row(random_row(), k == height - 1);
  endtask

  // single-row grids and the edge columns at full width
  task automatic test_single_row();
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row({1'b1, 62'd0, 1'b1}, 1'b1);
  endtask

  // blinker, solid and striped frames
  task automatic test_patterns();
    send_row('0, 1'b0);
    send_row(64'h8000_0000_0000_1C01, 1'b0);
    send_row('0, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row({32{2'b01}}, 1'b0);
    send_row({32{2'b10}}, 1'b1);
  endtask

  // width extremes, zero and beyond the hardware width among them
  task automatic test_width_extremes();
    write_grid_width(7'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_grid_width(7'd1);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_grid_width(7'd3);
    send_row('1, 1'b1);
    write_grid_width(7'd63);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_grid_width(7'd127);
    send_row('1, 1'b1);
  endtask

  // width changed while a row is held
  task automatic test_width_mid_frame();
    write_grid_width(7'd10);
    send_row(64'h0000_0000_0000_03FF, 1'b0);
    write_grid_width(7'd5);
    send_row('1, 1'b0);
    send_row(64'h0000_0000_0000_0155, 1'b1);
    write_grid_width(7'd64);
  endtask

  // receiver holds off while rows keep coming, so the block fills up
  task automatic test_fill_stall();
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 16; k++)
      send_row(random_row(), k == 15);
    steady = 1'b0;
  endtask

  // random frames with occasional width changes, some mid-frame
  task automatic test_random_frames();
    int height;
    int start;
    start = rows_sent;
    steady = 1'b1;
    while (rows_sent - start < RAND_ROWS) begin
      if (rows_sent - start > 60) steady = 1'b0;
      height = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) write_grid_width(random_width());
      if (height > 2 && $urandom_range(0, 7) == 0) begin
        send_row(random_row(), 1'b0);
        write_grid_width(random_width());
        send_frame(height - 1);
      end else begin
        send_frame(height);
      end
    end
    write_grid_width(7'd64);
  endtask

  // result receiver: random stalls, and a long hold-off on request
  always @(negedge clk) begin : receiver
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (steady || $urandom_range(0, 99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    lgrs_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result next_row=%h last_out=%b", $time, next_row, last_out);
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        if (next_row !== want.next_row) begin
          $display("%0t: next_row mismatch expected %h actual %h", $time, want.next_row,
                   next_row);
          fail_count++;
        end
        if (last_out !== want.last_out) begin
          $display("%0t: last_out mismatch expected %b actual %b", $time, want.last_out,
                   last_out);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken anywhere
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    row_cells = '0;
    last_row  = 1'b0;
    width_reg = lgrs_pkg::GRID_WIDTH_RESET;
    above_row = '0;
    held_row  = '0;
    row_held  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_row();
    test_patterns();
    test_width_extremes();
    test_width_mid_frame();
    test_fill_stall();
    test_random_frames();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_rows.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
